@@ hdl/mexp_pkg.sv @@
package mexp_pkg;

	// Default operand width
	localparam int WORD_BITS_DEF = 32;

	// Register indexes on the configuration port
	localparam int REG_MODULUS  = 0;
	localparam int REG_EXPONENT = 1;

	typedef logic [3:0] step_t;

	// Datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,      // take a base word from the input
		OP_SPECIAL,   // result for zero exponent or zero modulus
		OP_MUL_BASE,  // start base * 1 mod n (reduces the base)
		OP_WB_BASE,   // write the product back to the base register
		OP_SET_ACC,   // accumulator = 1 mod n
		OP_MUL_SQR,   // start acc * acc mod n
		OP_MUL_ACC,   // start acc * base mod n
		OP_WB_ACC,    // write the product back to the accumulator
		OP_DEC,       // step to the next lower exponent bit
		OP_EMIT       // hand the accumulator to the output register
	} op_t;

	// Jump conditions; a true condition loads the target, else the step counter advances
	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_INPUT,
		C_SPECIAL,
		C_MUL_BUSY,
		C_BIT_CLEAR,
		C_MORE_BITS,
		C_OUT_FULL,
		C_ALWAYS
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	localparam step_t STEP_WAIT = 4'd0;
	localparam step_t STEP_CHK  = 4'd1;
	localparam step_t STEP_RB   = 4'd2;
	localparam step_t STEP_RBW  = 4'd3;
	localparam step_t STEP_INIT = 4'd4;
	localparam step_t STEP_SQR  = 4'd5;
	localparam step_t STEP_SQW  = 4'd6;
	localparam step_t STEP_TST  = 4'd7;
	localparam step_t STEP_MUL  = 4'd8;
	localparam step_t STEP_MLW  = 4'd9;
	localparam step_t STEP_NXT  = 4'd10;
	localparam step_t STEP_OUT  = 4'd11;
	localparam step_t STEP_RET  = 4'd12;

	// Control program: left-to-right square-and-multiply
	function automatic ctrl_word_t prog_rom(input step_t addr);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_WAIT};
		case (addr)
			STEP_WAIT: w = '{op: OP_LOAD,     cond: C_NO_INPUT,  target: STEP_WAIT};
			STEP_CHK:  w = '{op: OP_SPECIAL,  cond: C_SPECIAL,   target: STEP_OUT};
			STEP_RB:   w = '{op: OP_MUL_BASE, cond: C_NEVER,     target: STEP_WAIT};
			STEP_RBW:  w = '{op: OP_WB_BASE,  cond: C_MUL_BUSY,  target: STEP_RBW};
			STEP_INIT: w = '{op: OP_SET_ACC,  cond: C_NEVER,     target: STEP_WAIT};
			STEP_SQR:  w = '{op: OP_MUL_SQR,  cond: C_NEVER,     target: STEP_WAIT};
			STEP_SQW:  w = '{op: OP_WB_ACC,   cond: C_MUL_BUSY,  target: STEP_SQW};
			STEP_TST:  w = '{op: OP_NOP,      cond: C_BIT_CLEAR, target: STEP_NXT};
			STEP_MUL:  w = '{op: OP_MUL_ACC,  cond: C_NEVER,     target: STEP_WAIT};
			STEP_MLW:  w = '{op: OP_WB_ACC,   cond: C_MUL_BUSY,  target: STEP_MLW};
			STEP_NXT:  w = '{op: OP_DEC,      cond: C_MORE_BITS, target: STEP_SQR};
			STEP_OUT:  w = '{op: OP_EMIT,     cond: C_OUT_FULL,  target: STEP_OUT};
			STEP_RET:  w = '{op: OP_NOP,      cond: C_ALWAYS,    target: STEP_WAIT};
			default:   w = '{op: OP_NOP,      cond: C_ALWAYS,    target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ hdl/mexp_mulmod.sv @@
// Modular multiplier: MSB-first shift-and-add, one bit of y per cycle.
// x must be below n; y may be any word.
module mexp_mulmod #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] n,
	output logic                 busy,
	output logic [WORD_BITS-1:0] product
);

	localparam int CNT_BITS = $clog2(WORD_BITS + 1);

	logic                 busy_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] dbl;
	logic [WORD_BITS-1:0] acc_d;

	// (a + b) mod n for a, b below n
	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] m
	);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[WORD_BITS-1:0];
	endfunction

	// One bit step: double, then add x if the current y bit is set
	always_comb begin
		dbl   = add_mod(acc_q, acc_q, n);
		acc_d = y_q[WORD_BITS-1] ? add_mod(dbl, x_q, n) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(WORD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= acc_d;
			y_q   <= {y_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

@@ hdl/modular_exponentiation.sv @@
// One word is in flight at a time; processing time per word depends on WORD_BITS and grows
// with each set exponent bit. A zero exponent or zero modulus bypasses the multiplier.
// Reset (arst_n low, asynchronous) clears control state, sets modulus 1 and exponent 0.
module modular_exponentiation #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF,
	localparam int DATA_BITS  = (WORD_BITS > 32) ? 64 : 32,
	localparam int ADDR_SHIFT = (WORD_BITS > 32) ? 3 : 2,
	localparam int ADDR_BITS  = ADDR_SHIFT + 1,
	localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_BITS-1:0]  paddr,
	input  logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]  prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_BITS-1:0] s_tdata,   // base_value
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_BITS-1:0] m_tdata    // power_result
);

	localparam int BIT_BITS   = $clog2(WORD_BITS);

	mexp_pkg::step_t      pc_q;
	mexp_pkg::ctrl_word_t cw;
	logic                 cond_hit;

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] exponent_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [BIT_BITS-1:0]  ebit_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_q;

	logic                 reg_idx;
	logic                 cfg_wr;
	logic [WORD_BITS-1:0] one_mod;
	logic                 special;
	logic                 out_full;

	logic                 mul_start;
	logic [WORD_BITS-1:0] mul_x;
	logic [WORD_BITS-1:0] mul_y;
	logic                 mul_busy;
	logic [WORD_BITS-1:0] mul_p;

	// Configuration registers
	assign reg_idx     = paddr[ADDR_SHIFT];
	assign cfg_wr      = psel && penable && pwrite;
	assign pready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WORD_BITS'(1);
			exponent_q <= '0;
		end else if (cfg_wr) begin
			if (reg_idx == 1'(mexp_pkg::REG_MODULUS))
				modulus_q <= pwdata[WORD_BITS-1:0];
			else
				exponent_q <= pwdata[WORD_BITS-1:0];
		end
	end

	always_comb begin
		if (reg_idx == 1'(mexp_pkg::REG_MODULUS))
			prdata = DATA_BITS'(modulus_q);
		else
			prdata = DATA_BITS'(exponent_q);
	end

	// Control word and jump condition
	assign cw       = mexp_pkg::prog_rom(pc_q);
	assign special  = (exponent_q == '0) || (modulus_q == '0);
	assign out_full = out_valid_q && !m_tready;
	assign one_mod  = (modulus_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

	always_comb begin
		case (cw.cond)
			mexp_pkg::C_NEVER:     cond_hit = 1'b0;
			mexp_pkg::C_NO_INPUT:  cond_hit = !s_tvalid;
			mexp_pkg::C_SPECIAL:   cond_hit = special;
			mexp_pkg::C_MUL_BUSY:  cond_hit = mul_busy;
			mexp_pkg::C_BIT_CLEAR: cond_hit = !exponent_q[ebit_q];
			mexp_pkg::C_MORE_BITS: cond_hit = (ebit_q != '0);
			mexp_pkg::C_OUT_FULL:  cond_hit = out_full;
			mexp_pkg::C_ALWAYS:    cond_hit = 1'b1;
			default:               cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= mexp_pkg::STEP_WAIT;
		else if (cond_hit)
			pc_q <= cw.target;
		else
			pc_q <= pc_q + 1'b1;
	end

	assign s_tready = (cw.op == mexp_pkg::OP_LOAD);

	// Multiplier operand selection
	always_comb begin
		mul_start = 1'b0;
		mul_x     = acc_q;
		mul_y     = acc_q;
		case (cw.op)
			mexp_pkg::OP_MUL_BASE: begin
				mul_start = 1'b1;
				mul_x     = one_mod;
				mul_y     = base_q;
			end
			mexp_pkg::OP_MUL_SQR: begin
				mul_start = 1'b1;
			end
			mexp_pkg::OP_MUL_ACC: begin
				mul_start = 1'b1;
				mul_y     = base_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.y       (mul_y),
		.n       (modulus_q),
		.busy    (mul_busy),
		.product (mul_p)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		case (cw.op)
			mexp_pkg::OP_LOAD: begin
				if (s_tvalid) begin
					base_q <= s_tdata[WORD_BITS-1:0];
					ebit_q <= BIT_BITS'(WORD_BITS - 1);
				end
			end
			mexp_pkg::OP_SPECIAL: begin
				acc_q <= (exponent_q == '0) ? WORD_BITS'(1) : '0;
			end
			mexp_pkg::OP_WB_BASE: begin
				if (!mul_busy)
					base_q <= mul_p;
			end
			mexp_pkg::OP_SET_ACC: begin
				acc_q <= one_mod;
			end
			mexp_pkg::OP_WB_ACC: begin
				if (!mul_busy)
					acc_q <= mul_p;
			end
			mexp_pkg::OP_DEC: begin
				if (ebit_q != '0)
					ebit_q <= ebit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.op == mexp_pkg::OP_EMIT && !out_full) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == mexp_pkg::OP_EMIT && !out_full)
			out_q <= acc_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_BITS'(out_q);

endmodule
